/* rtl/core/nlej_pkg.sv */
// ----------------------------------------------------------------------------
// nlej_pkg
// Types and constants shared by the nested loop equi-join engine.
// ----------------------------------------------------------------------------
package nlej_pkg;

  localparam int TABLE_DEPTH_DEF = 64;
  localparam int KEY_W           = 32;
  localparam int HANDLE_W        = 16;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_LOAD  = 2'd1,
    OP_PROBE = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_SCAN   = 2'd1,
    ST_FINISH = 2'd2
  } state_t;

  typedef struct packed {
    logic [1:0]              opcode;
    logic signed [KEY_W-1:0] join_key;
    logic [HANDLE_W-1:0]     text_handle;
  } in_item_t;

  typedef struct packed {
    logic [HANDLE_W-1:0] name_handle;
    logic [HANDLE_W-1:0] title_handle;
    logic                unmatched;
    logic                last_of_run;
  } out_item_t;

  typedef struct packed {
    logic [KEY_W-1:0]    key;
    logic [HANDLE_W-1:0] title;
  } row_t;

  typedef struct packed {
    logic shift;
    row_t row;
  } tbl_ctl_t;

endpackage

/* rtl/core/nlej_cell.sv */
// ----------------------------------------------------------------------------
// nlej_cell
// One table row; loads a new row or takes its neighbor's row on a shift.
// ----------------------------------------------------------------------------
module nlej_cell (
  input  logic                clk,
  input  nlej_pkg::tbl_ctl_t  ctl,
  input  logic                load,
  input  nlej_pkg::row_t      neighbor,
  output nlej_pkg::row_t      row
);
  import nlej_pkg::*;

  always_ff @(posedge clk) begin
    if (load) begin
      row <= ctl.row;
    end else if (ctl.shift) begin
      row <= neighbor;
    end
  end

endmodule

/* rtl/core/nlej_ctrl.sv */
// ----------------------------------------------------------------------------
// nlej_ctrl
// Sequencer: table loads, probe scan over the rotating row chain, results.
// ----------------------------------------------------------------------------
module nlej_ctrl #(
  parameter int TABLE_DEPTH = nlej_pkg::TABLE_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  nlej_pkg::in_item_t     in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output nlej_pkg::out_item_t    out_data,
  input  logic                   cfg_wen,
  input  logic                   cfg_wdata,
  input  nlej_pkg::row_t         head,
  output nlej_pkg::tbl_ctl_t     ctl,
  output logic [TABLE_DEPTH-1:0] load_sel
);
  import nlej_pkg::*;

  localparam int CW = $clog2(TABLE_DEPTH + 1);

  state_t              state, state_next;
  logic [CW-1:0]       count, count_next;
  logic [CW-1:0]       step, step_next;
  logic [KEY_W-1:0]    probe_key, probe_key_next;
  logic [HANDLE_W-1:0] probe_name, probe_name_next;
  out_item_t           pend, pend_next;
  logic                pend_valid, pend_valid_next;
  logic                out_valid_next;
  out_item_t           out_data_next;
  logic                mode;
  logic                hit, can_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      count      <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
      mode       <= 1'b0;
    end else begin
      state      <= state_next;
      count      <= count_next;
      pend_valid <= pend_valid_next;
      out_valid  <= out_valid_next;
      if (cfg_wen) begin
        mode <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    step       <= step_next;
    probe_key  <= probe_key_next;
    probe_name <= probe_name_next;
    pend       <= pend_next;
    out_data   <= out_data_next;
  end

  assign hit      = (step < count) && (head.key == probe_key);
  assign can_out  = !out_valid || !out_stall;
  assign in_stall = (state != ST_IDLE);

  always_comb begin
    state_next      = state;
    count_next      = count;
    step_next       = step;
    probe_key_next  = probe_key;
    probe_name_next = probe_name;
    pend_next       = pend;
    pend_valid_next = pend_valid;
    out_data_next   = out_data;
    out_valid_next  = out_valid && out_stall;
    ctl.shift       = 1'b0;
    ctl.row.key     = in_data.join_key;
    ctl.row.title   = in_data.text_handle;
    load_sel        = '0;

    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          case (in_data.opcode)
            OP_CLEAR: begin
              count_next = '0;
            end
            OP_LOAD: begin
              if (count < CW'(TABLE_DEPTH)) begin
                for (int i = 0; i < TABLE_DEPTH; i++) begin
                  load_sel[i] = (count == CW'(i));
                end
                count_next = count + 1'b1;
              end
            end
            OP_PROBE: begin
              probe_key_next  = in_data.join_key;
              probe_name_next = in_data.text_handle;
              step_next       = '0;
              pend_valid_next = 1'b0;
              state_next      = ST_SCAN;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (!(hit && pend_valid && !can_out)) begin
          ctl.shift = 1'b1;
          step_next = step + 1'b1;
          if (hit) begin
            if (pend_valid) begin
              out_data_next  = pend;
              out_valid_next = 1'b1;
            end
            pend_next.name_handle  = probe_name;
            pend_next.title_handle = head.title;
            pend_next.unmatched    = 1'b0;
            pend_next.last_of_run  = 1'b0;
            pend_valid_next        = 1'b1;
          end
          if (step == CW'(TABLE_DEPTH - 1)) begin
            state_next = ST_FINISH;
          end
        end
      end
      ST_FINISH: begin
        if (pend_valid) begin
          if (can_out) begin
            out_data_next             = pend;
            out_data_next.last_of_run = 1'b1;
            out_valid_next            = 1'b1;
            pend_valid_next           = 1'b0;
            state_next                = ST_IDLE;
          end
        end else if (mode) begin
          if (can_out) begin
            out_data_next.name_handle  = probe_name;
            out_data_next.title_handle = '0;
            out_data_next.unmatched    = 1'b1;
            out_data_next.last_of_run  = 1'b1;
            out_valid_next             = 1'b1;
            state_next                 = ST_IDLE;
          end
        end else begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

/* rtl/core/nested_loop_equi_join.sv */
// ----------------------------------------------------------------------------
// nested_loop_equi_join
// Equi-join engine over a table of record rows, inner or left outer.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall / in_data) takes clear, load and probe
// items. Clear empties the table; load appends a row (ignored when full);
// neither produces results. A probe scans the rows in load order and emits
// one output transfer per matching row, the final one marked last_of_run.
// In left outer mode (cfg_wdata = 1 written through cfg_wen) a probe with no
// match emits one transfer flagged unmatched with a zero title.
// Clear and load are taken without raising in_stall. A probe holds in_stall
// high through its scan and its finish step: the rows sit in a ring of cells
// that rotates one position per cycle past the compare at its head, unless a
// stalled output holds it, and a full turn restores the load order. A stalled
// output holds its result; the ring stops turning only when a second match
// would need the output slot.
// Reset (rst, synchronous) empties the table, selects inner mode and drops
// any pending result; row contents are not cleared.
// ----------------------------------------------------------------------------
module nested_loop_equi_join #(
  parameter int TABLE_DEPTH = nlej_pkg::TABLE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  nlej_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output nlej_pkg::out_item_t out_data,
  input  logic                cfg_wen,
  input  logic                cfg_wdata
);
  import nlej_pkg::*;

  tbl_ctl_t               ctl;
  logic [TABLE_DEPTH-1:0] load_sel;
  row_t                   rows [TABLE_DEPTH];

  nlej_ctrl #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_wen  (cfg_wen),
    .cfg_wdata(cfg_wdata),
    .head     (rows[0]),
    .ctl      (ctl),
    .load_sel (load_sel)
  );

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    nlej_cell u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .load    (load_sel[i]),
      .neighbor(rows[(i + 1) % TABLE_DEPTH]),
      .row     (rows[i])
    );
  end

endmodule

/* rtl/core/nlej_check.sv */
// ----------------------------------------------------------------------------
// nlej_check
// Port-level checks for the equi-join engine, bound to the top level.
// ----------------------------------------------------------------------------
module nlej_check (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input nlej_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_stall,
  input nlej_pkg::out_item_t out_data
);
  import nlej_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled output transfer changed");

  a_unmatched_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.unmatched |-> out_data.last_of_run &&
      out_data.title_handle == '0)
    else $error("unmatched result not last or title nonzero");

  a_probe_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && in_data.opcode == OP_PROBE |=> in_stall)
    else $error("probe did not start a scan");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("output or stall active after reset");

endmodule

bind nested_loop_equi_join nlej_check u_nlej_check (.*);

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the nested loop equi-join engine.
// ----------------------------------------------------------------------------
// A directed table covers the empty-table probe in both join modes, extreme
// keys, the unused opcode and clearing. Random phases follow, with clears,
// loads and probes over small key sets that force many matches, a full table,
// and different idle and stall patterns on both channels. One phase holds the
// output off for a long time so that the engine backs up. Every accepted
// transfer updates a local copy of the table, and each output transfer is
// compared with the oldest predicted result.
// ----------------------------------------------------------------------------
module tb_top;
  import nlej_pkg::*;

  localparam int          TABLE_DEPTH  = TABLE_DEPTH_DEF;
  localparam int          DRAIN_CYCLES = TABLE_DEPTH + 16;
  localparam int          HOLD_CYCLES  = 400;
  localparam int          LIMIT_CYCLES = 2_000_000;
  localparam logic [1:0]  OP_SPARE     = 2'd3;
  localparam logic        MODE_INNER   = 1'b0;
  localparam logic        MODE_LEFT    = 1'b1;

  typedef struct packed {
    logic      set_mode;
    logic      mode;
    in_item_t  item;
    logic      typed;
    out_item_t res;
  } step_t;

  localparam int N_DIRECTED = 17;
  localparam step_t DIRECTED [N_DIRECTED] = '{
    '{1'b1, MODE_LEFT,  '0, 1'b0, '0},
    '{1'b0, 1'b0, '{OP_PROBE, 32'h0000_0000, 16'h1234}, 1'b1,
      '{16'h1234, 16'h0000, 1'b1, 1'b1}},
    '{1'b0, 1'b0, '{OP_LOAD,  32'h8000_0000, 16'hFFFF}, 1'b0, '0},
    '{1'b0, 1'b0, '{OP_LOAD,  32'h7FFF_FFFF, 16'h0000}, 1'b0, '0},
    '{1'b0, 1'b0, '{OP_LOAD,  32'h8000_0000, 16'h5A5A}, 1'b0, '0},
    '{1'b0, 1'b0, '{OP_PROBE, 32'h8000_0000, 16'hFFFF}, 1'b0, '0},
    '{1'b0, 1'b0, '{OP_PROBE, 32'h7FFF_FFFF, 16'h0000}, 1'b1,
      '{16'h0000, 16'h0000, 1'b0, 1'b1}},
    '{1'b0, 1'b0, '{OP_PROBE, 32'hFFFF_FFFF, 16'hABCD}, 1'b1,
      '{16'hABCD, 16'h0000, 1'b1, 1'b1}},
    '{1'b0, 1'b0, '{OP_SPARE, 32'h7FFF_FFFF, 16'hFFFF}, 1'b0, '0},
    '{1'b0, 1'b0, '{OP_PROBE, 32'h7FFF_FFFF, 16'h0001}, 1'b1,
      '{16'h0001, 16'h0000, 1'b0, 1'b1}},
    '{1'b0, 1'b0, '{OP_CLEAR, 32'h0000_0000, 16'h0000}, 1'b0, '0},
    '{1'b0, 1'b0, '{OP_PROBE, 32'h8000_0000, 16'h0002}, 1'b1,
      '{16'h0002, 16'h0000, 1'b1, 1'b1}},
    '{1'b1, MODE_INNER, '0, 1'b0, '0},
    '{1'b0, 1'b0, '{OP_PROBE, 32'h0000_0000, 16'h0003}, 1'b0, '0},
    '{1'b0, 1'b0, '{OP_LOAD,  32'h0000_0005, 16'h0007}, 1'b0, '0},
    '{1'b0, 1'b0, '{OP_PROBE, 32'h0000_0006, 16'h0008}, 1'b0, '0},
    '{1'b0, 1'b0, '{OP_PROBE, 32'h0000_0005, 16'h0009}, 1'b1,
      '{16'h0009, 16'h0007, 1'b0, 1'b1}}
  };

  logic      clk = 1'b0;
  logic      rst;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;
  logic      cfg_wen;
  logic      cfg_wdata;

  logic signed [KEY_W-1:0] tbl_key   [TABLE_DEPTH];
  logic [HANDLE_W-1:0]     tbl_title [TABLE_DEPTH];
  int                      row_total;
  logic                    left_join;

  out_item_t               pending_pairs [$];
  out_item_t               probe_hits [$];
  logic signed [KEY_W-1:0] key_pool [6];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_asked     = 0;
  int hold_taken     = 0;
  int fail_count     = 0;
  int cycles         = 0;

  nested_loop_equi_join i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic join_predict(input in_item_t it);
    out_item_t r;
    probe_hits.delete();
    case (it.opcode)
      OP_CLEAR: row_total = 0;
      OP_LOAD: begin
        if (row_total < TABLE_DEPTH) begin
          tbl_key[row_total]   = it.join_key;
          tbl_title[row_total] = it.text_handle;
          row_total++;
        end
      end
      OP_PROBE: begin
        for (int i = 0; i < row_total; i++) begin
          if (tbl_key[i] == it.join_key) begin
            r.name_handle  = it.text_handle;
            r.title_handle = tbl_title[i];
            r.unmatched    = 1'b0;
            r.last_of_run  = 1'b0;
            probe_hits.push_back(r);
          end
        end
        if (probe_hits.size() == 0 && left_join) begin
          r.name_handle  = it.text_handle;
          r.title_handle = '0;
          r.unmatched    = 1'b1;
          r.last_of_run  = 1'b0;
          probe_hits.push_back(r);
        end
        if (probe_hits.size() > 0) begin
          r = probe_hits[probe_hits.size() - 1];
          r.last_of_run = 1'b1;
          probe_hits[probe_hits.size() - 1] = r;
        end
      end
      default: ;
    endcase
  endtask

  // drive at the falling edge, transfer at the rising edge
  task automatic send_item(input in_item_t it, input logic typed, input out_item_t fixed);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = it;
    do @(posedge clk); while (in_stall);
    join_predict(it);
    if (typed) pending_pairs.push_back(fixed);
    else foreach (probe_hits[i]) pending_pairs.push_back(probe_hits[i]);
  endtask

  task automatic wait_empty();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_pairs.size() != 0) @(posedge clk);
  endtask

  task automatic set_join_mode(input logic mode);
    wait_empty();
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_wen   = 1'b1;
    cfg_wdata = mode;
    @(negedge clk);
    cfg_wen   = 1'b0;
    left_join = mode;
  endtask

  task automatic refresh_pool();
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7FFF_FFFF;
    for (int i = 2; i < 6; i++) key_pool[i] = $urandom;
  endtask

  function automatic in_item_t rand_item(input int clr_pct, input int pool_n);
    in_item_t it;
    int       r;
    r = $urandom_range(99);
    it.text_handle = HANDLE_W'($urandom_range(16'hFFFF));
    if ($urandom_range(99) < 85) it.join_key = key_pool[$urandom_range(pool_n - 1)];
    else it.join_key = $urandom;
    if (r < clr_pct) it.opcode = OP_CLEAR;
    else if (r < 48) it.opcode = OP_LOAD;
    else if (r < 95) it.opcode = OP_PROBE;
    else it.opcode = OP_SPARE;
    return it;
  endfunction

  task automatic fill_table(input int n_rows, input int pool_n);
    in_item_t it;
    it.opcode      = OP_CLEAR;
    it.join_key    = $urandom;
    it.text_handle = HANDLE_W'($urandom_range(16'hFFFF));
    send_item(it, 1'b0, '0);
    for (int i = 0; i < n_rows; i++) begin
      it.opcode      = OP_LOAD;
      it.join_key    = key_pool[$urandom_range(pool_n - 1)];
      it.text_handle = HANDLE_W'($urandom_range(16'hFFFF));
      send_item(it, 1'b0, '0);
    end
  endtask

  task automatic run_phase(input logic mode, input int s_idle, input int r_stall,
                           input int n_items, input int pool_n, input int fill_rows);
    in_item_t it;
    int       sent;
    set_join_mode(mode);
    send_idle_pct  = s_idle;
    recv_stall_pct = r_stall;
    refresh_pool();
    if (fill_rows > 0) fill_table(fill_rows, pool_n);
    sent = 0;
    while (sent < n_items) begin
      it = rand_item(3, pool_n);
      send_item(it, 1'b0, '0);
      if (it.opcode != OP_SPARE) sent++;
    end
  endtask

  task automatic run_backpressure();
    in_item_t it;
    set_join_mode(MODE_LEFT);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    refresh_pool();
    fill_table(40, 2);
    hold_asked++;
    for (int i = 0; i < 12; i++) begin
      it.opcode      = OP_PROBE;
      it.join_key    = key_pool[$urandom_range(1)];
      it.text_handle = HANDLE_W'($urandom_range(16'hFFFF));
      send_item(it, 1'b0, '0);
    end
    wait_empty();
    for (int i = 0; i < 10; i++) send_item(rand_item(0, 2), 1'b0, '0);
  endtask

  initial begin : receiver
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_taken != hold_asked) begin
        hold_taken = hold_asked;
        out_stall  = 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        out_stall = ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_pairs.size() == 0) begin
        $error("unexpected result: %h", out_data);
        fail_count++;
      end else begin
        want = pending_pairs.pop_front();
        if (out_data.name_handle !== want.name_handle) begin
          $error("name_handle: expected %h, got %h", want.name_handle, out_data.name_handle);
          fail_count++;
        end
        if (out_data.title_handle !== want.title_handle) begin
          $error("title_handle: expected %h, got %h", want.title_handle,
                 out_data.title_handle);
          fail_count++;
        end
        if (out_data.unmatched !== want.unmatched) begin
          $error("unmatched: expected %b, got %b", want.unmatched, out_data.unmatched);
          fail_count++;
        end
        if (out_data.last_of_run !== want.last_of_run) begin
          $error("last_of_run: expected %b, got %b", want.last_of_run, out_data.last_of_run);
          fail_count++;
        end
      end
    end
  end

  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_wen   = 1'b0;
    cfg_wdata = 1'b0;
    row_total = 0;
    left_join = MODE_INNER;
    foreach (tbl_key[i]) begin
      tbl_key[i]   = '0;
      tbl_title[i] = '0;
    end
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int i = 0; i < N_DIRECTED; i++) begin
      if (DIRECTED[i].set_mode) set_join_mode(DIRECTED[i].mode);
      else send_item(DIRECTED[i].item, DIRECTED[i].typed, DIRECTED[i].res);
    end

    run_phase(MODE_INNER, 0,  0,  50, 4, 0);
    run_phase(MODE_LEFT,  88, 0,  40, 3, 0);
    run_phase(MODE_LEFT,  0,  88, 40, 2, 0);
    run_phase(MODE_INNER, 31, 31, 50, 6, 0);
    run_phase(MODE_LEFT,  0,  0,  24, 1, 66);
    run_backpressure();
    run_phase(MODE_INNER, 31, 31, 40, 5, 0);

    wait_empty();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/nlej_pkg.sv
rtl/core/nlej_cell.sv
rtl/core/nlej_ctrl.sv
rtl/core/nested_loop_equi_join.sv
rtl/core/nlej_check.sv
tb/tb_top.sv
